// ===== sv/assert_macros.svh =====
// Assertion helpers for the cache; all sample on clk and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every active edge
`define LKV_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define LKV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lkv_pkg.sv =====
`default_nettype none
package lkv_pkg;

  // Slot and rank fields in the token cover up to 256 cells
  localparam int IDX_W = 8;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Search token, handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             found;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] slot_rank;
    logic [VAL_W-1:0] value;
    logic             have_free;
    logic [IDX_W-1:0] free_slot;
    logic             have_victim;
    logic [IDX_W-1:0] victim;
  } lkv_tok_t;

  // Update broadcast from the controller to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] target;
    logic [IDX_W-1:0] thr;
    logic             wr_key;
    logic             wr_value;
    logic             set_valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_upd_t;

endpackage
`default_nettype wire

// ===== sv/lkv_cell.sv =====
`default_nettype none
module lkv_cell #(
  parameter int RANK_W = 4,
  parameter int INDEX  = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [lkv_pkg::KEY_W-1:0]     key_i,
  input  wire logic [lkv_pkg::IDX_W-1:0]     victim_rank_i,
  input  wire lkv_pkg::lkv_tok_t             tok_i,
  output lkv_pkg::lkv_tok_t                  tok_o,
  input  wire lkv_pkg::lkv_upd_t             upd_i
);

  logic                      valid_r;
  logic [RANK_W-1:0]         rank_r;
  logic [lkv_pkg::KEY_W-1:0] key_r;
  logic [lkv_pkg::VAL_W-1:0] value_r;
  lkv_pkg::lkv_tok_t         tok_r;
  lkv_pkg::lkv_tok_t         tok_nxt;

  logic                      match;
  logic                      is_victim;
  logic                      sel;
  logic [lkv_pkg::IDX_W-1:0] rank_ext;
  logic [lkv_pkg::IDX_W-1:0] my_idx;

  assign my_idx    = lkv_pkg::IDX_W'(INDEX);
  assign rank_ext  = lkv_pkg::IDX_W'(rank_r);
  assign match     = valid_r && (key_r == key_i);
  assign is_victim = valid_r && (rank_ext == victim_rank_i);
  assign sel       = upd_i.en && (upd_i.target == my_idx);

  // Fold this entry into the passing token: first match, first free, the victim
  always_comb begin
    tok_nxt = tok_i;
    if (match && !tok_i.found) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.slot      = my_idx;
      tok_nxt.slot_rank = rank_ext;
      tok_nxt.value     = value_r;
    end
    if (is_victim) begin
      tok_nxt.have_victim = 1'b1;
      tok_nxt.victim      = my_idx;
    end
    if (!valid_r && !tok_i.have_free) begin
      tok_nxt.have_free = 1'b1;
      tok_nxt.free_slot = my_idx;
    end
  end

  // Token stage towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  // Entry state: target takes rank 0 (and valid on insert), more recent entries age by one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd_i.en) begin
      if (sel) begin
        rank_r <= '0;
        if (upd_i.set_valid) begin
          valid_r <= 1'b1;
        end
      end else if (valid_r && (rank_ext < upd_i.thr)) begin
        rank_r <= rank_r + RANK_W'(1);
      end
    end
  end

  // Key and value, no reset
  always_ff @(posedge clk) begin
    if (sel && upd_i.wr_key) begin
      key_r <= upd_i.key;
    end
    if (sel && upd_i.wr_value) begin
      value_r <= upd_i.value;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Input channel in_*: in_tuser is the command (0 get, 1 put), in_tdata holds
// the key in bits 31:0 and the value in bits 63:32. Result channel out_*:
// out_tdata is the read value (stored value on a get hit, all ones on a miss,
// the written value on a put), out_tuser bit 0 is hit, bit 1 is evicted.
// cfg_wr_en/cfg_wr_data set the capacity (clamped to 1..MAX_ENTRIES); a write
// is ignored unless the store is empty.
// A request token walks a row of MAX_ENTRIES cells, one cell per cycle, each
// cell comparing its own key; the controller then broadcasts at most one update.
// One request is in flight at a time: the result appears in the same cycle
// in which in_tready rises, so a new input transfer is taken only once the
// last request is through; the pace of requests is set by the length of
// the cell chain.
// Reset empties the store and sets capacity to 16 (or MAX_ENTRIES if less).
// A stalled result is held in the output register; one more request may be
// taken and searched meanwhile, then it waits with its update and result
// until the output register frees up, and nothing further is accepted.
`default_nettype none
`include "assert_macros.svh"
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  wire logic [0:0]  in_tuser,   // command [0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // read_value [31:0]
  output logic [1:0]       out_tuser,  // hit [0], evicted [1]
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data
);

  localparam int RANK_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_RST = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam int IDX_W   = lkv_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                      state_r;
  logic                        start_r;
  logic                        req_cmd_r;
  logic [lkv_pkg::KEY_W-1:0]   req_key_r;
  logic [lkv_pkg::VAL_W-1:0]   req_value_r;
  lkv_pkg::lkv_tok_t           res_r;
  logic [CNT_W-1:0]            count_r;
  logic [lkv_pkg::CAP_W-1:0]   cap_r;
  logic                        out_valid_r;
  logic [31:0]                 out_data_r;
  logic                        out_hit_r;
  logic                        out_ev_r;

  lkv_pkg::lkv_tok_t           tok_w [MAX_ENTRIES+1];
  lkv_pkg::lkv_upd_t           upd;
  logic [IDX_W-1:0]            victim_rank;
  logic                        in_xfer;
  logic                        out_free;
  logic                        is_put;
  logic                        at_cap;
  logic                        do_evict;
  logic                        do_insert;
  logic [31:0]                 rd_value;
  logic [lkv_pkg::CAP_W-1:0]   cap_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign in_xfer     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign victim_rank = IDX_W'(count_r - CNT_W'(1));

  // Token injected at the head of the chain
  always_comb begin
    tok_w[0]        = '0;
    tok_w[0].active = start_r;
  end

  // Row of cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .RANK_W (RANK_W),
      .INDEX  (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .key_i         (req_key_r),
      .victim_rank_i (victim_rank),
      .tok_i         (tok_w[i]),
      .tok_o         (tok_w[i+1]),
      .upd_i         (upd)
    );
  end

  // Decide the action from the finished search
  assign is_put    = (req_cmd_r == lkv_pkg::CMD_PUT);
  assign at_cap    = (32'(count_r) >= 32'(cap_r));
  assign do_evict  = is_put && !res_r.found && (at_cap || !res_r.have_free)
                     && res_r.have_victim;
  assign do_insert = is_put && !res_r.found && !do_evict && res_r.have_free;

  always_comb begin
    upd           = '0;
    upd.en        = (state_r == S_DONE) && out_free &&
                    (res_r.found || do_evict || do_insert);
    upd.wr_key    = do_evict || do_insert;
    upd.wr_value  = is_put;
    upd.set_valid = do_insert;
    upd.key       = req_key_r;
    upd.value     = req_value_r;
    if (res_r.found) begin
      upd.target = res_r.slot;
      upd.thr    = res_r.slot_rank;
    end else if (do_evict) begin
      upd.target = res_r.victim;
      upd.thr    = IDX_W'(count_r - CNT_W'(1));
    end else begin
      upd.target = res_r.free_slot;
      upd.thr    = IDX_W'(count_r);
    end
  end

  always_comb begin
    if (is_put) begin
      rd_value = req_value_r;
    end else if (res_r.found) begin
      rd_value = res_r.value;
    end else begin
      rd_value = '1;
    end
  end

  // Capacity clamp
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_nxt = lkv_pkg::CAP_W'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_ENTRIES)) begin
      cap_nxt = lkv_pkg::CAP_W'(MAX_ENTRIES);
    end else begin
      cap_nxt = cfg_wr_data;
    end
  end

  // Controller: state, request, count, capacity and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      cap_r       <= lkv_pkg::CAP_W'(CAP_RST);
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_xfer;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en && (count_r == '0)) begin
        cap_r <= cap_nxt;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            req_cmd_r   <= in_tuser[0];
            req_key_r   <= in_tdata[31:0];
            req_value_r <= in_tdata[63:32];
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_w[MAX_ENTRIES].active) begin
            res_r   <= tok_w[MAX_ENTRIES];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= rd_value;
            out_hit_r   <= res_r.found;
            out_ev_r    <= do_evict;
            if (do_insert) begin
              count_r <= count_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_ev_r, out_hit_r};

  // Checks
  `LKV_ASSERT_ALWAYS(a_count_cap, 32'(count_r) <= 32'(cap_r), "entry count above capacity")
  `LKV_ASSERT_IMPL(a_hit_ev, out_valid_r, !(out_hit_r && out_ev_r), "hit and eviction together")
  `LKV_ASSERT_IMPL(a_evict_full, upd.en && do_evict, 32'(count_r) == 32'(cap_r), "eviction below capacity")
  `LKV_ASSERT_NEXT(a_busy, in_xfer, !in_tready && start_r, "request accepted while busy")

endmodule
`default_nettype wire
